// ===== sv/gcd_pkg.sv =====
// Shared constants and types for the great-circle distance pipeline.
package gcd_pkg;

   // Fixed-point angle constants (radians in Q60 and Q62, angles in 2^-24 degree).
   localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] DEG_Q60     = PI_Q60 / 64'd180;
   localparam logic [63:0] HALF_PI_Q62 = {PI_Q60[62:0], 1'b0};
   localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;

   // Angle arguments before and after reduction.
   localparam int ANG_W  = 35;
   localparam int WRAP_W = 33;
   localparam int FOLD_W = 31;
   localparam logic [WRAP_W-1:0] QUARTER_U   = 33'd1509949440;
   localparam logic [WRAP_W-1:0] HALF_TURN_U = 33'd3019898880;
   localparam logic [WRAP_W-1:0] TURN_U      = 33'd6039797760;

   // Pipeline depths.
   localparam int MUL_LAT    = 2;
   localparam int NUM_TERMS  = 15;
   localparam int TERM_LAT   = 2 * MUL_LAT + 1;
   localparam int SINE_LAT   = MUL_LAT + NUM_TERMS * TERM_LAT;
   localparam int ANGLE_LAT  = 3 + MUL_LAT;
   localparam int HSUM_LAT   = 2 * MUL_LAT + 1;
   localparam int SRCH_HI    = 62;
   localparam int SRCH_LO    = 20;
   localparam int SRCH_STEPS = SRCH_HI - SRCH_LO + 1;
   localparam int SRCH_LAT   = SINE_LAT + MUL_LAT + 1;
   localparam int OUT_LAT    = 2 + MUL_LAT;
   localparam int PIPE_LAT   = ANGLE_LAT + SINE_LAT + HSUM_LAT
                               + SRCH_STEPS * SRCH_LAT + OUT_LAT;

   // Output scaling: miles * 2^16 = (t * 791976 + 100 * 2^25) / (100 * 2^26).
   localparam int T_W       = 64 - SRCH_LO;
   localparam logic [19:0] DIAM_X100 = 20'd791976;
   localparam logic [63:0] OUT_HALF  = 64'd3355443200;
   localparam int OUT_SHIFT = 26;
   localparam int N_W       = 38;
   localparam logic [6:0] OUT_DIV = 7'd100;
   localparam int RCP_SHIFT = N_W + 6;
   localparam logic [63:0] OUT_RCP = 64'((128'd1 << RCP_SHIFT) / 128'd100);
   localparam int DIST_W    = 30;
   localparam logic [DIST_W-1:0] DIST_MAX = 30'd815300000;

   // State handed from one Taylor term cell to the next.
   typedef struct packed {
      logic [63:0] term;
      logic [63:0] x2;
      logic [63:0] sum;
   } taylor_type;

   // State handed from one arcsine search cell to the next.
   typedef struct packed {
      logic [63:0] theta;
      logic [63:0] h;
      logic        sat;
      logic        in_range;
   } srch_type;

endpackage

// ===== sv/gcd_mul64.sv =====
// Two-stage 64x64 multiplier returning 64 bits of the product above a fixed shift.
module gcd_mul64 #(
   parameter int SHIFT = 62
) (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0]  ll_in, lh_in, hl_in, hh_in;
   logic [63:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [191:0] full;
   logic [63:0]  p_in, p_ff;

   always_comb begin
      ll_in = 64'(a[31:0])  * 64'(b[31:0]);
      lh_in = 64'(a[31:0])  * 64'(b[63:32]);
      hl_in = 64'(a[63:32]) * 64'(b[31:0]);
      hh_in = 64'(a[63:32]) * 64'(b[63:32]);
      full  = ({128'd0, hh_ff} << 64) + ({128'd0, lh_ff} << 32)
            + ({128'd0, hl_ff} << 32) + {128'd0, ll_ff};
      p_in  = full[SHIFT +: 64];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

// ===== sv/gcd_term_cell.sv =====
// One Taylor term of the sine series: multiply by x^2, divide by (2K)(2K+1), accumulate.
module gcd_term_cell #(
   parameter int K = 1
) (
   input  logic                clock,
   input  logic                en,
   input  gcd_pkg::taylor_type cell_in,
   output gcd_pkg::taylor_type cell_out
);

   localparam int D         = 2 * K * (2 * K + 1);
   localparam int L         = $clog2(D + 1) - 1;
   localparam int DIV_SHIFT = 64 + L;
   localparam logic [63:0] RCP = 64'((192'd1 << DIV_SHIFT) / D);
   localparam int DW        = $clog2(D + 1);
   localparam int RW        = 64 + DW;
   localparam int ALIGN     = 2 * gcd_pkg::MUL_LAT;

   logic [63:0]         prod, q_est, q;
   logic [63:0]         x2_ff   [ALIGN];
   logic [63:0]         sum_ff  [ALIGN];
   logic [63:0]         prod_ff [gcd_pkg::MUL_LAT];
   logic [RW-1:0]       qd, rem;
   gcd_pkg::taylor_type out_in, out_ff;

   gcd_mul64 #(.SHIFT(62)) u_mul_x2 (
      .clock(clock), .en(en), .a(cell_in.term), .b(cell_in.x2), .p(prod)
   );

   // Division by the constant as a reciprocal product; the estimate is at most one low.
   gcd_mul64 #(.SHIFT(DIV_SHIFT)) u_mul_rcp (
      .clock(clock), .en(en), .a(prod), .b(RCP), .p(q_est)
   );

   always_comb begin
      qd          = RW'(q_est) * RW'(D);
      rem         = {{DW{1'b0}}, prod_ff[gcd_pkg::MUL_LAT-1]} - qd;
      q           = (rem >= RW'(D)) ? q_est + 64'd1 : q_est;
      out_in.term = q;
      out_in.x2   = x2_ff[ALIGN-1];
      out_in.sum  = (K % 2 == 1) ? sum_ff[ALIGN-1] - q : sum_ff[ALIGN-1] + q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff[0]   <= cell_in.x2;
         sum_ff[0]  <= cell_in.sum;
         prod_ff[0] <= prod;
         for (int i = 1; i < ALIGN; i++) begin
            x2_ff[i]  <= x2_ff[i-1];
            sum_ff[i] <= sum_ff[i-1];
         end
         for (int i = 1; i < gcd_pkg::MUL_LAT; i++) begin
            prod_ff[i] <= prod_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;

endmodule

// ===== sv/gcd_sine.sv =====
// Pipelined Q62 sine as a row of Taylor term cells, with a side payload kept in step.
module gcd_sine #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       x,
   input  logic [SIDE_W-1:0] side_in,
   output logic [63:0]       s,
   output logic [SIDE_W-1:0] side_out
);

   localparam int LAT = gcd_pkg::SINE_LAT;

   logic [63:0]         x2;
   logic [63:0]         x_ff    [gcd_pkg::MUL_LAT];
   logic [SIDE_W-1:0]   side_ff [LAT];
   gcd_pkg::taylor_type chain   [gcd_pkg::NUM_TERMS+1];

   gcd_mul64 #(.SHIFT(62)) u_mul_sq (
      .clock(clock), .en(en), .a(x), .b(x), .p(x2)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x;
         side_ff[0] <= side_in;
         for (int i = 1; i < gcd_pkg::MUL_LAT; i++) begin
            x_ff[i] <= x_ff[i-1];
         end
         for (int i = 1; i < LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign chain[0] = '{term: x_ff[gcd_pkg::MUL_LAT-1], x2: x2,
                       sum: x_ff[gcd_pkg::MUL_LAT-1]};

   for (genvar k = 0; k < gcd_pkg::NUM_TERMS; k++) begin : g_term
      gcd_term_cell #(.K(k + 1)) u_cell (
         .clock(clock), .en(en), .cell_in(chain[k]), .cell_out(chain[k+1])
      );
   end

   assign s        = chain[gcd_pkg::NUM_TERMS].sum;
   assign side_out = side_ff[LAT-1];

endmodule

// ===== sv/gcd_search_cell.sv =====
// One bit of the arcsine search: keep the bit if sin^2 of the candidate stays within h.
module gcd_search_cell #(
   parameter int BIT = 62
) (
   input  logic              clock,
   input  logic              en,
   input  gcd_pkg::srch_type st_in,
   output gcd_pkg::srch_type st_out
);

   localparam int SIDE_W = $bits(gcd_pkg::srch_type);
   localparam logic [63:0] STEP = 64'd1 << BIT;

   logic [63:0]       cand, s, sq;
   gcd_pkg::srch_type side_pre, side_sin, out_in, out_ff;
   gcd_pkg::srch_type side_ff [gcd_pkg::MUL_LAT];

   always_comb begin
      cand              = st_in.theta | STEP;
      side_pre          = st_in;
      side_pre.in_range = (cand <= gcd_pkg::HALF_PI_Q62);
   end

   gcd_sine #(.SIDE_W(SIDE_W)) u_sine (
      .clock(clock), .en(en), .x(cand), .side_in(side_pre),
      .s(s), .side_out(side_sin)
   );

   gcd_mul64 #(.SHIFT(62)) u_mul_sq (
      .clock(clock), .en(en), .a(s), .b(s), .p(sq)
   );

   always_comb begin
      out_in = side_ff[gcd_pkg::MUL_LAT-1];
      if (out_in.in_range && (sq <= out_in.h)) begin
         out_in.theta = out_in.theta | STEP;
      end
      out_in.in_range = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_sin;
         for (int i = 1; i < gcd_pkg::MUL_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         out_ff <= out_in;
      end
   end

   assign st_out = out_ff;

endmodule

// ===== sv/great_circle_distance.sv =====
// Top level of the haversine great-circle distance pipeline.
//
// The block takes a transaction carrying two points (latitude and longitude in signed degrees
// scaled by 2^23) and returns one transaction with the great-circle distance between them in
// miles scaled by 2^16, on an earth radius of 3959.88 miles, rounded to nearest. When rounding
// pushes the haversine sum to one or above, the distance saturates at half the circumference.
// The design is a fully pipelined chain: one transaction can be accepted on every clock unless
// the output stalls. The depth of the pipeline is set by the arcsine, which is found one bit
// at a time over 43 search cells, each of which runs its own 15-term sine pipeline followed
// by a squaring multiplier. The whole pipeline advances together; it holds only while a
// finished result sits in the output register and the consumer is not ready, so req_ready
// follows rsp_ready in that case. No state is kept between transactions and no
// configuration is needed.
module great_circle_distance (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [30:0]  req_lat_a,
   input  logic signed [31:0]  req_lon_a,
   input  logic signed [30:0]  req_lat_b,
   input  logic signed [31:0]  req_lon_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [29:0]         rsp_distance_miles
);

   localparam int ANG_W    = gcd_pkg::ANG_W;
   localparam int WRAP_W   = gcd_pkg::WRAP_W;
   localparam int FOLD_W   = gcd_pkg::FOLD_W;
   localparam int MUL_LAT  = gcd_pkg::MUL_LAT;
   localparam int PIPE_LAT = gcd_pkg::PIPE_LAT;
   localparam int STEPS    = gcd_pkg::SRCH_STEPS;
   localparam int NUM_ANG  = 4;
   // Angle slots: latitude difference, longitude difference, and the two cosine arguments.
   localparam int ANG_DLAT = 0;
   localparam int ANG_DLON = 1;
   localparam int ANG_CA   = 2;
   localparam int ANG_CB   = 3;
   // Position in the valid line of the register holding the last search cell's result.
   localparam int SRCH_DONE_IDX = PIPE_LAT - gcd_pkg::OUT_LAT - 1;

   // The pipeline moves unless a result is held at the output.
   logic en;
   logic [PIPE_LAT-1:0] valid_in, valid_ff;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign valid_in  = {valid_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_LAT-1];

   // ---------------------------------------------------------------------------------------
   // Angle preparation. All angles are in units of 2^-24 degree, so the half differences of
   // the haversine are the plain differences of the inputs, and cos(lat) is sin(2*lat + 90).
   // ---------------------------------------------------------------------------------------
   logic [ANG_W-1:0]  sx_lat_a, sx_lon_a, sx_lat_b, sx_lon_b;
   logic [ANG_W-1:0]  u_in    [NUM_ANG];
   logic [ANG_W-1:0]  u_ff    [NUM_ANG];
   logic [WRAP_W-1:0] wrap_in [NUM_ANG];
   logic [WRAP_W-1:0] wrap_ff [NUM_ANG];
   logic [FOLD_W-1:0] fold_in [NUM_ANG];
   logic [FOLD_W-1:0] fold_ff [NUM_ANG];
   logic              neg_in  [NUM_ANG];
   logic              neg_ff  [NUM_ANG];
   logic [MUL_LAT-1:0] negd_ff [NUM_ANG];
   logic [63:0]       x_rad   [NUM_ANG];
   logic [63:0]       s_mag   [NUM_ANG];
   logic              s_neg   [NUM_ANG];

   always_comb begin
      sx_lat_a = {{(ANG_W-31){req_lat_a[30]}}, req_lat_a};
      sx_lat_b = {{(ANG_W-31){req_lat_b[30]}}, req_lat_b};
      sx_lon_a = {{(ANG_W-32){req_lon_a[31]}}, req_lon_a};
      sx_lon_b = {{(ANG_W-32){req_lon_b[31]}}, req_lon_b};
      u_in[ANG_DLAT] = sx_lat_b - sx_lat_a;
      u_in[ANG_DLON] = sx_lon_b - sx_lon_a;
      u_in[ANG_CA]   = sx_lat_a + sx_lat_a + ANG_W'(gcd_pkg::QUARTER_U);
      u_in[ANG_CB]   = sx_lat_b + sx_lat_b + ANG_W'(gcd_pkg::QUARTER_U);
   end

   // Every argument lies within one turn of zero, so a single conditional add reduces it.
   always_comb begin
      for (int j = 0; j < NUM_ANG; j++) begin
         wrap_in[j] = u_ff[j][ANG_W-1] ?
                      WRAP_W'(u_ff[j] + ANG_W'(gcd_pkg::TURN_U)) : WRAP_W'(u_ff[j]);
      end
   end

   // The upper half turn maps onto the lower one with a sign flip, and the second quadrant
   // mirrors onto the first.
   always_comb begin
      logic [WRAP_W-1:0] r;
      for (int j = 0; j < NUM_ANG; j++) begin
         r         = wrap_ff[j];
         neg_in[j] = 1'b0;
         if (r >= gcd_pkg::HALF_TURN_U) begin
            r         = r - gcd_pkg::HALF_TURN_U;
            neg_in[j] = 1'b1;
         end
         if (r > gcd_pkg::QUARTER_U) begin
            r = gcd_pkg::HALF_TURN_U - r;
         end
         fold_in[j] = FOLD_W'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < NUM_ANG; j++) begin
            u_ff[j]    <= u_in[j];
            wrap_ff[j] <= wrap_in[j];
            fold_ff[j] <= fold_in[j];
            neg_ff[j]  <= neg_in[j];
            negd_ff[j] <= {negd_ff[j][MUL_LAT-2:0], neg_ff[j]};
         end
      end
   end

   // Conversion to Q62 radians followed by the four sine pipelines; the sign rides along.
   for (genvar j = 0; j < NUM_ANG; j++) begin : g_angle
      gcd_mul64 #(.SHIFT(22)) u_mul_rad (
         .clock(clock), .en(en), .a(64'(fold_ff[j])), .b(gcd_pkg::DEG_Q60),
         .p(x_rad[j])
      );
      gcd_sine #(.SIDE_W(1)) u_sine (
         .clock(clock), .en(en), .x(x_rad[j]), .side_in(negd_ff[j][MUL_LAT-1]),
         .s(s_mag[j]), .side_out(s_neg[j])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Haversine sum h = sin^2(dlat) + cos(a) * cos(b) * sin^2(dlon), kept as magnitude and sign.
   // ---------------------------------------------------------------------------------------
   logic [63:0]          p1, sdo2, cab, p2;
   logic [63:0]          p1d_ff [MUL_LAT];
   logic [2*MUL_LAT-1:0] cneg_ff;
   logic                 cneg;
   logic [63:0]          h_in, h_ff;
   logic                 sat_in, sat_ff;

   gcd_mul64 #(.SHIFT(62)) u_mul_p1 (
      .clock(clock), .en(en), .a(s_mag[ANG_DLAT]), .b(s_mag[ANG_DLAT]), .p(p1)
   );
   gcd_mul64 #(.SHIFT(62)) u_mul_sdo2 (
      .clock(clock), .en(en), .a(s_mag[ANG_DLON]), .b(s_mag[ANG_DLON]), .p(sdo2)
   );
   gcd_mul64 #(.SHIFT(62)) u_mul_cab (
      .clock(clock), .en(en), .a(s_mag[ANG_CA]), .b(s_mag[ANG_CB]), .p(cab)
   );
   gcd_mul64 #(.SHIFT(62)) u_mul_p2 (
      .clock(clock), .en(en), .a(cab), .b(sdo2), .p(p2)
   );

   assign cneg = cneg_ff[2*MUL_LAT-1];

   // A negative cosine product, only possible for latitudes past the poles, is subtracted and the sum clamps at zero.
   always_comb begin
      if (cneg) begin
         h_in = (p2 >= p1d_ff[MUL_LAT-1]) ? 64'd0 : p1d_ff[MUL_LAT-1] - p2;
      end else begin
         h_in = p1d_ff[MUL_LAT-1] + p2;
      end
      sat_in = (h_in >= gcd_pkg::ONE_Q62);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cneg_ff   <= {cneg_ff[2*MUL_LAT-2:0], s_neg[ANG_CA] ^ s_neg[ANG_CB]};
         p1d_ff[0] <= p1;
         for (int i = 1; i < MUL_LAT; i++) begin
            p1d_ff[i] <= p1d_ff[i-1];
         end
         h_ff   <= h_in;
         sat_ff <= sat_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Arcsine of sqrt(h) by bit search, most significant bit first, one cell per bit.
   // ---------------------------------------------------------------------------------------
   gcd_pkg::srch_type stg [STEPS+1];

   assign stg[0] = '{theta: 64'd0, h: h_ff, sat: sat_ff, in_range: 1'b0};

   for (genvar i = 0; i < STEPS; i++) begin : g_search
      gcd_search_cell #(.BIT(gcd_pkg::SRCH_HI - i)) u_cell (
         .clock(clock), .en(en), .st_in(stg[i]), .st_out(stg[i+1])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Scaling to miles: 2 * R * theta, divided by 100 * 2^26 with rounding half up. The shift
   // is taken first, then the division by 100 uses a reciprocal product and one correction.
   // ---------------------------------------------------------------------------------------
   logic [63:0]                 theta_fin, nprod, qe, qd, rem, q;
   logic [gcd_pkg::T_W-1:0]     t;
   logic [gcd_pkg::N_W-1:0]     n_in, n_ff;
   logic [gcd_pkg::N_W-1:0]     nd_ff [MUL_LAT];
   logic [gcd_pkg::DIST_W-1:0]  dist_in, dist_ff;

   always_comb begin
      theta_fin = stg[STEPS].sat ? gcd_pkg::HALF_PI_Q62 : stg[STEPS].theta;
      t         = theta_fin[63:gcd_pkg::SRCH_LO];
      nprod     = 64'(t) * 64'(gcd_pkg::DIAM_X100) + gcd_pkg::OUT_HALF;
      n_in      = nprod[gcd_pkg::OUT_SHIFT +: gcd_pkg::N_W];
   end

   gcd_mul64 #(.SHIFT(gcd_pkg::RCP_SHIFT)) u_mul_out (
      .clock(clock), .en(en), .a(64'(n_ff)), .b(gcd_pkg::OUT_RCP), .p(qe)
   );

   always_comb begin
      qd      = qe * 64'(gcd_pkg::OUT_DIV);
      rem     = 64'(nd_ff[MUL_LAT-1]) - qd;
      q       = (rem >= 64'(gcd_pkg::OUT_DIV)) ? qe + 64'd1 : qe;
      dist_in = q[gcd_pkg::DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= n_in;
         nd_ff[0] <= n_ff;
         for (int i = 1; i < MUL_LAT; i++) begin
            nd_ff[i] <= nd_ff[i-1];
         end
         dist_ff <= dist_in;
      end
   end

   assign rsp_distance_miles = dist_ff;

`ifndef ASSERT_OFF
   // A result never exceeds half the circumference.
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance_miles <= gcd_pkg::DIST_MAX))
      else $error("distance beyond half circumference");

   // The search never settles on an angle beyond a right angle.
   a_theta_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[SRCH_DONE_IDX] |-> (stg[STEPS].theta <= gcd_pkg::HALF_PI_Q62))
      else $error("search angle beyond pi/2");

   // While a result is held at the output, no transaction moves anywhere in the pipeline.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(valid_ff))
      else $error("pipeline moved during output stall");

   // A saturated search result is captured by the scaling stage when the pipeline moves.
   a_sat_path: assert property (@(posedge clock) disable iff (reset)
      (en && valid_ff[SRCH_DONE_IDX] && stg[STEPS].sat) |=> (n_ff == $past(n_in)))
      else $error("saturated search result lost on its way to scaling");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the great-circle distance pipeline.
`timescale 1ns / 1ps

module tb_top;

   // One point pair as it is offered on the request channel.
   typedef struct packed {
      logic signed [30:0] lat_a;
      logic signed [31:0] lon_a;
      logic signed [30:0] lat_b;
      logic signed [31:0] lon_b;
   } point_pair_type;

   localparam int        RANDOM_PAIRS = 1530;
   localparam longint    DEG          = 64'sd8388608;   // One degree in input units.
   localparam int        DRAIN_CYCLES = 3700;           // A little over the pipeline latency.
   // The long stall starts just after the first results reach the output, while the driver
   // still has transactions queued.
   localparam int        HOLD_START   = 3600;
   localparam int        HOLD_CYCLES  = 5000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic signed [30:0]  req_lat_a;
   logic signed [31:0]  req_lon_a;
   logic signed [30:0]  req_lat_b;
   logic signed [31:0]  req_lon_b;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [29:0]         rsp_distance_miles;

   point_pair_type pending_pairs[$];
   logic [29:0]    dist_expected[$];
   int             error_count;
   int             cycle_count;

   great_circle_distance i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_lat_a          (req_lat_a),
      .req_lon_a          (req_lon_a),
      .req_lat_b          (req_lat_b),
      .req_lon_b          (req_lon_b),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distance_miles (rsp_distance_miles)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Distance predictor. All angle arithmetic is done in units of
   // 2^-24 degree and Q62 radians, with every product truncated exactly
   // as the hardware does, so the expected value is bit exact.
   // ------------------------------------------------------------------

   // (a * b) >> s over the full 128-bit product.
   function automatic logic [63:0] mul_trunc(input logic [63:0] a, input logic [63:0] b,
                                             input int s);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod >> s);
   endfunction

   // Sine of a Q62 radian value in [0, pi/2], by a 15-term Taylor series.
   function automatic logic [63:0] sine_q62(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      x2   = mul_trunc(x, x, 62);
      term = x;
      acc  = x;
      for (int k = 1; k <= 15; k++) begin
         term = mul_trunc(term, x2, 62) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else            acc = acc + term;
      end
      return acc;
   endfunction

   // Signed sine of an angle in 2^-24 degree: wrap to one turn, then fold
   // into the first quadrant and restore the sign.
   function automatic longint sine_of_angle(input longint u);
      longint      r;
      longint      quarter;
      longint      turn;
      logic        neg;
      logic [63:0] s;
      quarter = longint'(gcd_pkg::QUARTER_U);
      turn    = longint'(gcd_pkg::TURN_U);
      r       = u % turn;
      neg     = 1'b0;
      if (r < 0) r = r + turn;
      if (r >= 2 * quarter) begin
         r   = r - 2 * quarter;
         neg = 1'b1;
      end
      if (r > quarter) r = 2 * quarter - r;
      s = sine_q62(mul_trunc(64'(r), gcd_pkg::DEG_Q60, 22));
      return neg ? -longint'(s) : longint'(s);
   endfunction

   // Signed Q62 product whose magnitude is truncated.
   function automatic longint signed_mul_q62(input longint a, input longint b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] r;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      r  = mul_trunc(ma, mb, 62);
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic [29:0] predict_distance(input point_pair_type p);
      longint       lat_a;
      longint       lat_b;
      longint       sin_dlat;
      longint       sin_dlon;
      longint       cos_a;
      longint       cos_b;
      logic [63:0]  lat_term;
      longint       lon_term;
      logic [63:0]  hsum;
      logic [63:0]  theta;
      logic [63:0]  cand;
      logic [63:0]  s;
      logic [127:0] scaled;
      lat_a    = longint'(p.lat_a);
      lat_b    = longint'(p.lat_b);
      sin_dlat = sine_of_angle(lat_b - lat_a);
      sin_dlon = sine_of_angle(longint'(p.lon_b) - longint'(p.lon_a));
      cos_a    = sine_of_angle(2 * lat_a + longint'(gcd_pkg::QUARTER_U));
      cos_b    = sine_of_angle(2 * lat_b + longint'(gcd_pkg::QUARTER_U));
      lat_term = signed_mul_q62(sin_dlat, sin_dlat);
      lon_term = signed_mul_q62(signed_mul_q62(cos_a, cos_b),
                                signed_mul_q62(sin_dlon, sin_dlon));
      // A negative sum can only come from latitudes past the poles; it clamps to zero.
      if (lon_term < 0) begin
         hsum = (64'(-lon_term) >= lat_term) ? 64'd0 : lat_term - 64'(-lon_term);
      end else begin
         hsum = lat_term + 64'(lon_term);
      end
      theta = 64'd0;
      // A sum at or above one saturates at half the circumference.
      if (hsum >= gcd_pkg::ONE_Q62) begin
         theta = gcd_pkg::HALF_PI_Q62;
      end else begin
         for (int b = 62; b >= 20; b--) begin
            cand = theta | (64'd1 << b);
            if (cand <= gcd_pkg::HALF_PI_Q62) begin
               s = sine_q62(cand);
               if (mul_trunc(s, s, 62) <= hsum) theta = cand;
            end
         end
      end
      scaled = ({64'd0, theta >> 20} * 128'd791976 + 128'd3355443200) / 128'd6710886400;
      return scaled[29:0];
   endfunction

   // ------------------------------------------------------------------
   // Stimulus: directed corner pairs first, then random pairs. Most
   // random pairs stay within or near the legal degree ranges; one in five
   // are raw bit patterns so that every input bit toggles and angles wrap.
   // ------------------------------------------------------------------
   function automatic point_pair_type build_pair(input longint la, input longint oa,
                                                 input longint lb, input longint ob);
      point_pair_type p;
      p.lat_a = la[30:0];
      p.lon_a = oa[31:0];
      p.lat_b = lb[30:0];
      p.lon_b = ob[31:0];
      return p;
   endfunction

   task automatic add_pair(input point_pair_type pr);
      pending_pairs = {pending_pairs, pr};
   endtask

   function automatic longint random_span(input longint lim);
      return longint'($urandom_range(32'(2 * lim))) - lim;
   endfunction

   initial begin
      point_pair_type p;
      // Identical points give zero distance.
      add_pair(build_pair(0, 0, 0, 0));
      add_pair(build_pair(45 * DEG, 100 * DEG, 45 * DEG, 100 * DEG));
      // Latitude and longitude extremes of the legal range.
      add_pair(build_pair(90 * DEG, 0, -90 * DEG, 0));
      add_pair(build_pair(-90 * DEG, -180 * DEG, 90 * DEG, 180 * DEG));
      add_pair(build_pair(0, -180 * DEG, 0, 180 * DEG));
      add_pair(build_pair(90 * DEG, 180 * DEG, 90 * DEG, -180 * DEG));
      // Antipodal points: the sum rounds to one or just above and must saturate.
      add_pair(build_pair(0, 0, 0, 180 * DEG));
      add_pair(build_pair(30 * DEG, 10 * DEG, -30 * DEG, -170 * DEG));
      add_pair(build_pair(0, -90 * DEG, 0, 90 * DEG));
      // Smallest nonzero steps.
      add_pair(build_pair(0, 0, 1, 0));
      add_pair(build_pair(0, 0, 0, 1));
      add_pair(build_pair(-1, -1, 1, 1));
      // Latitudes past the poles whose cosine product cancels the sum to zero.
      add_pair(build_pair(120 * DEG, 0, 60 * DEG, 180 * DEG));
      add_pair(build_pair(-120 * DEG, 50 * DEG, -60 * DEG, -130 * DEG));
      add_pair(build_pair(100 * DEG, 0, 80 * DEG, 180 * DEG));
      // Raw extremes of the field widths, wrapping modulo one turn.
      add_pair(build_pair(-(64'sd1 << 30), -(64'sd1 << 31),
                          (64'sd1 << 30) - 1, (64'sd1 << 31) - 1));
      add_pair(build_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1,
                          -(64'sd1 << 30), -(64'sd1 << 31)));
      add_pair(build_pair(-1, -1, -1, -1));
      // A few ordinary city-scale distances.
      add_pair(build_pair(40 * DEG, -74 * DEG, 51 * DEG, 0));
      add_pair(build_pair(-33 * DEG, 151 * DEG, 35 * DEG, 139 * DEG));
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         case ($urandom_range(9))
            0, 1: begin
               // Raw bit patterns over the whole field width.
               p.lat_a = 31'($urandom());
               p.lon_a = $urandom();
               p.lat_b = 31'($urandom());
               p.lon_b = $urandom();
            end
            2: begin
               // Nearby points: tiny differences stress the small-angle end.
               p = build_pair(random_span(90 * DEG), random_span(180 * DEG), 0, 0);
               p.lat_b = p.lat_a + 31'($signed($urandom_range(2000)) - 1000);
               p.lon_b = p.lon_a + 32'($signed($urandom_range(2000)) - 1000);
            end
            3: begin
               // Near-antipodal points exercise the saturation edge.
               p = build_pair(random_span(90 * DEG), random_span(180 * DEG), 0, 0);
               p.lat_b = -p.lat_a + 31'($signed($urandom_range(200)) - 100);
               p.lon_b = p.lon_a + 32'(180 * DEG) + 32'($signed($urandom_range(200)) - 100);
            end
            default: begin
               p = build_pair(random_span(90 * DEG), random_span(180 * DEG),
                              random_span(90 * DEG), random_span(180 * DEG));
            end
         endcase
         add_pair(p);
      end
   end

   // ------------------------------------------------------------------
   // Driver. It sends transactions in bursts of random length separated
   // by random gaps; a pending transaction is held steady until accepted.
   // The expected distance is predicted at the moment of acceptance.
   // ------------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      point_pair_type p;
      if (reset) begin
         req_valid  <= 1'b0;
         req_lat_a  <= '0;
         req_lon_a  <= '0;
         req_lat_b  <= '0;
         req_lon_b  <= '0;
         burst_left <= $urandom_range(20, 1);
         gap_left   <= 0;
      end else begin
         int burst_n;
         int gap_n;
         burst_n = burst_left;
         gap_n   = gap_left;
         if (req_valid && req_ready) begin
            p.lat_a = req_lat_a;
            p.lon_a = req_lon_a;
            p.lat_b = req_lat_b;
            p.lon_b = req_lon_b;
            dist_expected = {dist_expected, predict_distance(p)};
            burst_n--;
            if (burst_n <= 0) begin
               burst_n = $urandom_range(20, 1);
               // Roughly a third of the bursts run straight into the next one.
               gap_n   = ($urandom_range(2) == 0) ? 0 : $urandom_range(60, 1);
            end
         end
         if (!req_valid || req_ready) begin
            if (gap_n > 0) begin
               gap_n--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               p = pending_pairs.pop_front();
               req_valid <= 1'b1;
               req_lat_a <= p.lat_a;
               req_lon_a <= p.lon_a;
               req_lat_b <= p.lat_b;
               req_lon_b <= p.lon_b;
            end else begin
               req_valid <= 1'b0;
            end
         end
         burst_left <= burst_n;
         gap_left   <= gap_n;
      end
   end

   // ------------------------------------------------------------------
   // Receiver. Ready follows a pattern that cycles through always-ready,
   // lightly stalled, heavily stalled and periodic phases. Once in the run
   // it holds off for a long stretch so that the pipeline backs up and
   // stalls the request side while the driver keeps offering transactions.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         rsp_ready   <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else begin
            case ((cycle_count / 300) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(3) != 0);
               2:       rsp_ready <= ($urandom_range(4) == 0);
               default: rsp_ready <= ((cycle_count % 7) < 4);
            endcase
         end
      end
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Monitor: every accepted result is checked against the oldest prediction.
   always @(posedge clock) begin
      logic [29:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dist_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected distance %0d", rsp_distance_miles));
         end else begin
            want = dist_expected.pop_front();
            if (rsp_distance_miles !== want)
               report_mismatch($sformatf("distance_miles got %0d expected %0d",
                                         rsp_distance_miles, want));
         end
      end
   end

   // Reset once, then wait for the last transaction to drain and finish.
   initial begin
      error_count = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_pairs.size() > 0 || req_valid || dist_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && dist_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #(12 * 600000);
      $display("timeout, %0d results outstanding", dist_expected.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
